FILE: design/damped_oscillator_node_step_assert.svh
// ----------------------------------------------------------------------------
// oscillator node step assertion macros
// shared assertion forms for the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef DAMPED_OSCILLATOR_NODE_STEP_ASSERT_SVH
`define DAMPED_OSCILLATOR_NODE_STEP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent match
`define DONS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent match
`define DONS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dons_pkg.sv
// ----------------------------------------------------------------------------
// oscillator node step package
// widths, codes, register reset values and fixed-point helpers
// ----------------------------------------------------------------------------
package dons_pkg;

  // node storage
  localparam int NODE_COUNT = 1024;
  localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NODE_W     = 10;
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 65;
  localparam int CFG_IDX_W  = 3;

  // opcodes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_INIT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_OVER_DAMPING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL    = 3'd5;

  // register reset values
  localparam logic [30:0]        RST_DAMPING_RATE     = 31'd6553600;
  localparam logic [31:0]        RST_STEP_LENGTH      = 32'd429497;
  localparam logic [30:0]        RST_INVERSE_STEP     = 31'd655360000;
  localparam logic [31:0]        RST_DECAY_FACTOR     = 32'd4252231525;
  localparam logic [30:0]        RST_TWO_OVER_DAMPING = 31'd1311;
  localparam logic signed [31:0] RST_INITIAL_LEVEL    = 32'sd0;

  // saturation bounds in product width
  localparam logic signed [PROD_W-1:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -65'sd2147483648;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    clip;
  } sat_t;

  // per item control that rides down the pipeline
  typedef struct packed {
    logic                    op;
    logic [NODE_W-1:0]       node;
    logic                    in_range;
    logic signed [VAL_W-1:0] q;
  } tag_t;

  // one memory word per node
  typedef struct packed {
    logic signed [VAL_W-1:0] drive;
    logic signed [VAL_W-1:0] level;
    logic signed [VAL_W-1:0] rate;
  } node_state_t;

  // clip a wide signed value to the q16.16 range
  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val  = 32'sh7fffffff;
      r.clip = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val  = 32'sh80000000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[VAL_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // signed value times unsigned 32 bit operand, exact
  function automatic logic signed [PROD_W-1:0] mul_u(input logic signed [VAL_W-1:0] a,
                                                     input logic [VAL_W-1:0] b);
    logic signed [PROD_W-1:0] ae;
    logic signed [PROD_W-1:0] be;
    ae = PROD_W'(a);
    be = $signed({33'd0, b});
    return ae * be;
  endfunction

endpackage

FILE: design/damped_oscillator_node_step.sv
// ----------------------------------------------------------------------------
// damped oscillator node step
// per-node critically damped oscillator update, state held in one memory
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              beat
//  in        input      in_valid / in_stall    opcode, node, drive
//  out       output     out_valid / out_stall  node_out, level_out, saturated
//  cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one item per cycle while in_stall is low, through a seven stage pipeline
//  into the output register; one multiply in stages 1-4 and 6, two in stage 5
//  an item naming a node still in the pipeline waits until that node's
//  write-back in stage 7, which closes the read-modify-write loop
//  after reset a clearing pass writes zero to all NODE_COUNT (1024) entries,
//  one a cycle, with in_stall high; config writes are taken throughout
//  out_stall holds the output register; bubbles in the pipeline still fill
//
module damped_oscillator_node_step (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [dons_pkg::NODE_W-1:0]         node,
  input  logic signed [dons_pkg::VAL_W-1:0]   drive,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dons_pkg::NODE_W-1:0]         node_out,
  output logic signed [dons_pkg::VAL_W-1:0]   level_out,
  output logic                                saturated,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dons_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dons_pkg::VAL_W-1:0]          cfg_data
);

  localparam int AW = dons_pkg::ADDR_W;
  localparam int VW = dons_pkg::VAL_W;
  localparam int PW = dons_pkg::PROD_W;
  localparam int NS = 7;

  // configuration registers
  logic [30:0]          damping_rate;
  logic [31:0]          step_length;
  logic [30:0]          inverse_step;
  logic [31:0]          decay_factor;
  logic [30:0]          two_over_damping;
  logic signed [VW-1:0] initial_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_rate     <= dons_pkg::RST_DAMPING_RATE;
      step_length      <= dons_pkg::RST_STEP_LENGTH;
      inverse_step     <= dons_pkg::RST_INVERSE_STEP;
      decay_factor     <= dons_pkg::RST_DECAY_FACTOR;
      two_over_damping <= dons_pkg::RST_TWO_OVER_DAMPING;
      initial_level    <= dons_pkg::RST_INITIAL_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dons_pkg::REG_DAMPING_RATE:     damping_rate     <= cfg_data[30:0];
        dons_pkg::REG_STEP_LENGTH:      step_length      <= cfg_data;
        dons_pkg::REG_INVERSE_STEP:     inverse_step     <= cfg_data[30:0];
        dons_pkg::REG_DECAY_FACTOR:     decay_factor     <= cfg_data;
        dons_pkg::REG_TWO_OVER_DAMPING: two_over_damping <= cfg_data[30:0];
        dons_pkg::REG_INITIAL_LEVEL:    initial_level    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NS:1]     valid;
  logic [NS+1:1]   adv;
  dons_pkg::tag_t  tag [1:NS];
  logic            hazard;
  logic            clearing;
  logic [AW-1:0]   clr_addr;
  logic            accept;

  always_comb begin
    adv[NS+1] = !out_valid || !out_stall;
    for (int i = NS; i >= 1; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  // interlock on a node that has not been written back yet
  always_comb begin
    hazard = 1'b0;
    for (int i = 1; i <= NS; i++) begin
      if (valid[i] && (tag[i].node == node)) hazard = 1'b1;
    end
  end

  assign in_stall = clearing || !adv[1] || hazard;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[1]) valid[1] <= accept;
      for (int i = 2; i <= NS; i++) begin
        if (adv[i]) valid[i] <= valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      tag[1].op       <= opcode;
      tag[1].node     <= node;
      tag[1].in_range <= 32'(node) < 32'(dons_pkg::NODE_COUNT);
      tag[1].q        <= drive;
    end
    for (int i = 2; i <= NS; i++) begin
      if (adv[i]) tag[i] <= tag[i-1];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(dons_pkg::NODE_COUNT - 1)) clearing <= 1'b0;
    end
  end

  // node state memory
  dons_pkg::node_state_t mem [0:dons_pkg::NODE_COUNT-1];
  dons_pkg::node_state_t rd;
  dons_pkg::node_state_t wr_data;
  dons_pkg::node_state_t wb_data;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic                  wb_en;

  always_ff @(posedge clk) begin
    if (adv[1]) rd <= mem[AW'(node)];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // stage 1: drive difference times inverse step
  dons_pkg::sat_t       e1;
  logic signed [PW-1:0] pr1;
  always_comb begin
    e1  = dons_pkg::sat32(PW'(tag[1].q) - PW'(rd.drive));
    pr1 = dons_pkg::mul_u(e1.val, {1'b0, inverse_step});
  end

  logic signed [VW-1:0] p2, y2, r2;
  logic signed [PW-1:0] prod2;
  logic                 clip2;
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      p2    <= rd.drive;
      y2    <= rd.level;
      r2    <= rd.rate;
      prod2 <= pr1;
      clip2 <= e1.clip;
    end
  end

  // stage 2: d, then times two over damping
  dons_pkg::sat_t       d2;
  logic signed [PW-1:0] pr2;
  always_comb begin
    d2  = dons_pkg::sat32(prod2 >>> 16);
    pr2 = dons_pkg::mul_u(d2.val, {1'b0, two_over_damping});
  end

  logic signed [VW-1:0] p3, y3, r3, d3;
  logic signed [PW-1:0] prod3;
  logic                 clip3;
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      p3    <= p2;
      y3    <= y2;
      r3    <= r2;
      d3    <= d2.val;
      prod3 <= pr2;
      clip3 <= clip2 | d2.clip;
    end
  end

  // stage 3: f and a, then a times damping rate
  dons_pkg::sat_t       f3;
  dons_pkg::sat_t       a3;
  logic signed [PW-1:0] pr3;
  always_comb begin
    f3  = dons_pkg::sat32(prod3 >>> 16);
    a3  = dons_pkg::sat32(PW'(p3) - PW'(f3.val) - PW'(y3));
    pr3 = dons_pkg::mul_u(a3.val, {1'b0, damping_rate});
  end

  logic signed [VW-1:0] r4, d4, f4, a4;
  logic signed [PW-1:0] prod4;
  logic                 clip4;
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      r4    <= r3;
      d4    <= d3;
      f4    <= f3.val;
      a4    <= a3.val;
      prod4 <= pr3;
      clip4 <= clip3 | f3.clip | a3.clip;
    end
  end

  // stage 4: c, then times step length
  dons_pkg::sat_t       ga4;
  dons_pkg::sat_t       c4;
  logic signed [PW-1:0] pr4;
  always_comb begin
    ga4 = dons_pkg::sat32(prod4 >>> 16);
    c4  = dons_pkg::sat32(PW'(r4) - PW'(ga4.val) - PW'(d4));
    pr4 = dons_pkg::mul_u(c4.val, step_length);
  end

  logic signed [VW-1:0] d5, f5, a5, c5;
  logic signed [PW-1:0] prod5;
  logic                 clip5;
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d5    <= d4;
      f5    <= f4;
      a5    <= a4;
      c5    <= c4.val;
      prod5 <= pr4;
      clip5 <= clip4 | ga4.clip | c4.clip;
    end
  end

  // stage 5: k, then times damping rate and times decay factor
  dons_pkg::sat_t       m5;
  dons_pkg::sat_t       k5;
  logic signed [PW-1:0] prg5;
  logic signed [PW-1:0] prdec5;
  always_comb begin
    m5     = dons_pkg::sat32(prod5 >>> 32);
    k5     = dons_pkg::sat32(PW'(m5.val) - PW'(a5));
    prg5   = dons_pkg::mul_u(k5.val, {1'b0, damping_rate});
    prdec5 = dons_pkg::mul_u(k5.val, decay_factor);
  end

  logic signed [VW-1:0] d6, f6, c6;
  logic signed [PW-1:0] pg6, pdec6;
  logic                 clip6;
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      d6    <= d5;
      f6    <= f5;
      c6    <= c5;
      pg6   <= prg5;
      pdec6 <= prdec5;
      clip6 <= clip5 | m5.clip | k5.clip;
    end
  end

  // stage 6: new level, and c minus gamma k times decay factor
  dons_pkg::sat_t       gk6;
  dons_pkg::sat_t       mk6;
  dons_pkg::sat_t       lv6;
  dons_pkg::sat_t       cg6;
  logic signed [PW-1:0] pr6;
  always_comb begin
    gk6 = dons_pkg::sat32(pg6 >>> 16);
    mk6 = dons_pkg::sat32(pdec6 >>> 32);
    lv6 = dons_pkg::sat32(PW'(mk6.val) + PW'(tag[6].q) - PW'(f6));
    cg6 = dons_pkg::sat32(PW'(c6) - PW'(gk6.val));
    pr6 = dons_pkg::mul_u(cg6.val, decay_factor);
  end

  logic signed [VW-1:0] d7, lvl7;
  logic signed [PW-1:0] prod7;
  logic                 clip7;
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      d7    <= d6;
      lvl7  <= lv6.val;
      prod7 <= pr6;
      clip7 <= clip6 | gk6.clip | mk6.clip | lv6.clip | cg6.clip;
    end
  end

  // stage 7: new rate and write-back
  dons_pkg::sat_t md7;
  dons_pkg::sat_t rt7;
  logic           clip_all;
  logic           is_init;
  always_comb begin
    md7      = dons_pkg::sat32(prod7 >>> 32);
    rt7      = dons_pkg::sat32(PW'(md7.val) + PW'(d7));
    clip_all = clip7 | md7.clip | rt7.clip;
    is_init  = (tag[7].op == dons_pkg::OP_INIT);
  end

  always_comb begin
    wb_en = valid[7] && adv[NS+1] && tag[7].in_range;
    if (is_init) begin
      wb_data.drive = initial_level;
      wb_data.level = initial_level;
      wb_data.rate  = '0;
    end else begin
      wb_data.drive = tag[7].q;
      wb_data.level = lvl7;
      wb_data.rate  = rt7.val;
    end
  end

  // clearing pass owns the write port right after reset
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = wb_en;
      wr_addr = AW'(tag[7].node);
      wr_data = wb_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv[NS+1]) begin
      out_valid <= valid[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS+1]) begin
      node_out <= tag[7].node;
      if (!tag[7].in_range) begin
        level_out <= '0;
        saturated <= 1'b0;
      end else if (is_init) begin
        level_out <= initial_level;
        saturated <= 1'b0;
      end else begin
        level_out <= lvl7;
        saturated <= clip_all;
      end
    end
  end

endmodule

FILE: design/dons_checker.sv
// ----------------------------------------------------------------------------
// oscillator node step checker
// port-level checks on the interlock, reset clearing and output hold
// ----------------------------------------------------------------------------
`include "damped_oscillator_node_step_assert.svh"

module dons_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [dons_pkg::NODE_W-1:0]       node,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [dons_pkg::NODE_W-1:0]       node_out,
  input logic signed [dons_pkg::VAL_W-1:0] level_out,
  input logic                              saturated
);

  localparam int BEAT_W = dons_pkg::NODE_W + dons_pkg::VAL_W + 1;

  logic                        in_beat;
  logic                        same_node;
  logic                        out_wait;
  logic [BEAT_W-1:0]           out_beat;
  logic [dons_pkg::NODE_W-1:0] prev_node;

  // node offered in the previous cycle
  always_ff @(posedge clk) begin
    prev_node <= node;
  end

  assign in_beat   = in_valid && !in_stall;
  assign same_node = in_valid && (node == prev_node);
  assign out_wait  = out_valid && out_stall;
  assign out_beat  = {node_out, level_out, saturated};

  // a node just taken in cannot be taken again the next cycle
  `DONS_ASSERT_NOW(a_same_node_waits, in_beat ##1 same_node, in_stall, "same node taken twice")

  // the clearing pass blocks input right after reset
  `DONS_ASSERT_NOW(a_clear_after_reset, $fell(rst), in_stall, "input open during clearing")

  // a stalled result beat holds
  `DONS_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_beat), "stalled beat changed")

endmodule

bind damped_oscillator_node_step dons_checker u_dons_checker (.*);

FILE: tb/damped_oscillator_node_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// damped oscillator node step checker
// watches the input, output and register channels, keeps its own copy of the
// per-node oscillator state and settings, and compares every output beat
// ----------------------------------------------------------------------------
module damped_oscillator_node_step_checker
  import dons_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    opcode,
  input  logic [NODE_W-1:0]       node,
  input  logic signed [VAL_W-1:0] drive,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [NODE_W-1:0]       node_out,
  input  logic signed [VAL_W-1:0] level_out,
  input  logic                    saturated,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data,
  output int                      mismatches,
  output int                      pending,
  output int                      results_seen,
  output int                      clipped_seen
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int     PRINT_CAP = 40;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic signed [VAL_W-1:0] level;
    logic                    clip;
  } level_beat_t;

  level_beat_t level_queue[$];

  // settings as the block should hold them
  logic [30:0]             gamma_q;
  logic [31:0]             dt_q;
  logic [30:0]             inv_step_q;
  logic [31:0]             decay_q;
  logic [30:0]             two_over_q;
  logic signed [VAL_W-1:0] init_level_q;

  // per-node state, zero from the start like the cleared memory
  int drive_mem [NODE_COUNT];
  int level_mem [NODE_COUNT];
  int rate_mem  [NODE_COUNT];

  bit clip_flag;

  // clip to the q16.16 range and remember any clip
  function automatic int clamp32(input longint v);
    if (v > Q_MAX) begin
      clip_flag = 1'b1;
      return 2147483647;
    end else if (v < Q_MIN) begin
      clip_flag = 1'b1;
      return -2147483647 - 1;
    end
    return int'(v);
  endfunction

  // q16.16 times q16.16, floor
  function automatic int mul_q16(input int a, input longint b);
    return clamp32((longint'(a) * b) >>> 16);
  endfunction

  // q16.16 times unsigned q0.32, floor
  function automatic int mul_q32(input int a, input longint b);
    return clamp32((longint'(a) * b) >>> 32);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // work out the beat that one input item causes and update the node
  task automatic predict_level(input logic op, input logic [NODE_W-1:0] nd, input int q);
    level_beat_t want;
    int p, y, r, d, f, a, ga, c, k, gk, lvl, rt;
    clip_flag  = 1'b0;
    want.node  = nd;
    want.level = '0;
    if (nd < NODE_COUNT) begin
      if (op == OP_INIT) begin
        drive_mem[nd] = init_level_q;
        level_mem[nd] = init_level_q;
        rate_mem[nd]  = 0;
        want.level    = init_level_q;
      end else begin
        p   = drive_mem[nd];
        y   = level_mem[nd];
        r   = rate_mem[nd];
        d   = mul_q16(clamp32(longint'(q) - p), inv_step_q);
        f   = mul_q16(d, two_over_q);
        a   = clamp32(longint'(p) - f - y);
        ga  = mul_q16(a, gamma_q);
        c   = clamp32(longint'(r) - ga - d);
        k   = clamp32(longint'(mul_q32(c, dt_q)) - a);
        gk  = mul_q16(k, gamma_q);
        lvl = clamp32(longint'(mul_q32(k, decay_q)) + q - f);
        rt  = clamp32(longint'(mul_q32(clamp32(longint'(c) - gk), decay_q)) + d);
        drive_mem[nd] = q;
        level_mem[nd] = lvl;
        rate_mem[nd]  = rt;
        want.level    = lvl;
      end
    end
    want.clip = clip_flag;
    level_queue.push_back(want);
  endtask

  // compare one output beat with the oldest expectation
  task automatic check_level();
    level_beat_t want;
    results_seen++;
    if (saturated === 1'b1)
      clipped_seen++;
    if (level_queue.size() == 0) begin
      report_mismatch("output beat with nothing expected, node", node_out, 0);
    end else begin
      want = level_queue.pop_front();
      if (node_out !== want.node)
        report_mismatch("node_out", node_out, want.node);
      if (level_out !== want.level)
        report_mismatch($sformatf("level_out of node %0d", want.node),
                        longint'(level_out), longint'(want.level));
      if (saturated !== want.clip)
        report_mismatch($sformatf("saturated of node %0d", want.node), saturated, want.clip);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gamma_q      = RST_DAMPING_RATE;
      dt_q         = RST_STEP_LENGTH;
      inv_step_q   = RST_INVERSE_STEP;
      decay_q      = RST_DECAY_FACTOR;
      two_over_q   = RST_TWO_OVER_DAMPING;
      init_level_q = RST_INITIAL_LEVEL;
      level_queue.delete();
      pending <= 0;
    end else begin
      // input beat
      if (in_valid && !in_stall)
        predict_level(opcode, node, drive);
      // register write, unknown indexes leave everything alone
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DAMPING_RATE:     gamma_q      = cfg_data[30:0];
          REG_STEP_LENGTH:      dt_q         = cfg_data;
          REG_INVERSE_STEP:     inv_step_q   = cfg_data[30:0];
          REG_DECAY_FACTOR:     decay_q      = cfg_data;
          REG_TWO_OVER_DAMPING: two_over_q   = cfg_data[30:0];
          REG_INITIAL_LEVEL:    init_level_q = cfg_data;
          default: ;
        endcase
      end
      // output beat
      if (out_valid && !out_stall)
        check_level();
      pending <= level_queue.size();
    end
  end

endmodule

FILE: tb/tb_damped_oscillator_node_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// damped oscillator node step testbench
// drives node load and step items through several register settings, from a
// short directed set to long random init-then-step runs, with random gaps and
// stalls on both sides; a checker beside the block predicts every output beat
// ----------------------------------------------------------------------------
module tb_damped_oscillator_node_step;
  import dons_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int IDLE_PERCENT   = 16;

  // indexes past the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [VAL_W-1:0] LEVEL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] LEVEL_MIN = 32'sh80000000;
  localparam logic signed [VAL_W-1:0] ONE       = 32'sd65536;
  localparam logic [NODE_W-1:0]       TOP_NODE  = NODE_W'(NODE_COUNT - 1);

  // reset register values at the write width
  localparam logic [VAL_W-1:0] W_DAMPING_RATE     = VAL_W'(RST_DAMPING_RATE);
  localparam logic [VAL_W-1:0] W_INVERSE_STEP     = VAL_W'(RST_INVERSE_STEP);
  localparam logic [VAL_W-1:0] W_TWO_OVER_DAMPING = VAL_W'(RST_TWO_OVER_DAMPING);

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    opcode    = OP_STEP;
  logic [NODE_W-1:0]       node      = '0;
  logic signed [VAL_W-1:0] drive     = '0;
  logic                    out_stall = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_DAMPING_RATE;
  logic [VAL_W-1:0]        cfg_data  = '0;

  logic                    in_stall;
  logic                    out_valid;
  logic [NODE_W-1:0]       node_out;
  logic signed [VAL_W-1:0] level_out;
  logic                    saturated;
  logic                    cfg_ready;

  logic steady   = 1'b0;
  logic hold_off = 1'b0;

  int items_sent;
  int inits_sent;
  int reg_writes;
  int idle_cycles;
  int mismatches;
  int pending;
  int results_seen;
  int clipped_seen;

  always #HALF_PERIOD clk = ~clk;

  damped_oscillator_node_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .node      (node),
    .drive     (drive),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .node_out  (node_out),
    .level_out (level_out),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  damped_oscillator_node_step_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .node         (node),
    .drive        (drive),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .node_out     (node_out),
    .level_out    (level_out),
    .saturated    (saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .clipped_seen (clipped_seen)
  );

  // receiver: random stalls, none in steady stretches, plus the long hold
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= hold_off || (!steady && ($urandom_range(99) < IDLE_PERCENT));
  end

  // long receiver hold while the sender keeps offering, fills the pipeline
  initial begin
    wait (items_sent >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no beat for %0d cycles, %0d results still expected",
               $time, idle_cycles, pending);
      $display("** damped_oscillator_node_step: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat, after a random gap
  task automatic send_item(input logic op, input logic [NODE_W-1:0] nd,
                           input logic signed [VAL_W-1:0] q);
    while (!steady && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    node     <= nd;
    drive    <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_INIT)
      inits_sent++;
  endtask

  // stop offering and wait for every expected beat
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one register beat, valid left high for the caller to lower
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // full register set, optionally followed by writes to unused indexes
  task automatic load_settings(input logic [VAL_W-1:0] gamma, input logic [VAL_W-1:0] dt,
                               input logic [VAL_W-1:0] inv_dt, input logic [VAL_W-1:0] decay,
                               input logic [VAL_W-1:0] two_over, input logic [VAL_W-1:0] lvl,
                               input bit spare);
    write_reg(REG_DAMPING_RATE, gamma);
    write_reg(REG_STEP_LENGTH, dt);
    write_reg(REG_INVERSE_STEP, inv_dt);
    write_reg(REG_DECAY_FACTOR, decay);
    write_reg(REG_TWO_OVER_DAMPING, two_over);
    write_reg(REG_INITIAL_LEVEL, lvl);
    if (spare) begin
      write_reg(REG_SPARE_6, $urandom());
      write_reg(REG_SPARE_7, $urandom());
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly small drives, some full range, some at the rails
  function automatic logic signed [VAL_W-1:0] pick_drive();
    case ($urandom_range(9))
      5, 6, 7: return $urandom();
      8:       return LEVEL_MAX;
      9:       return LEVEL_MIN;
      default: return $urandom_range(0, 20 * 65536) - 10 * 65536;
    endcase
  endfunction

  // load-then-step runs on one node, with stray items mixed in
  task automatic run_sequences(input int n);
    int target;
    int len;
    logic [NODE_W-1:0] nd;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 20) begin
        send_item(1'($urandom_range(1)), NODE_W'($urandom_range(NODE_COUNT - 1)),
                  $urandom());
      end else begin
        nd  = $urandom_range(1) ? NODE_W'($urandom_range(7))
                                : NODE_W'($urandom_range(NODE_COUNT - 1));
        len = $urandom_range(2, 12);
        send_item(OP_INIT, nd, $urandom());
        repeat (len) send_item(OP_STEP, nd, pick_drive());
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // rails: load at the top level, then step against both rails and zero
    load_settings(W_DAMPING_RATE, RST_STEP_LENGTH, W_INVERSE_STEP, RST_DECAY_FACTOR,
                  W_TWO_OVER_DAMPING, LEVEL_MAX, 1'b1);
    send_item(OP_INIT, '0, $urandom());
    send_item(OP_INIT, TOP_NODE, $urandom());
    send_item(OP_STEP, '0, LEVEL_MIN);
    send_item(OP_STEP, TOP_NODE, LEVEL_MAX);
    send_item(OP_STEP, '0, '0);
    send_item(OP_STEP, TOP_NODE, LEVEL_MIN);
    drain_results();

    // bottom level load, drive field ignored on load
    load_settings(W_DAMPING_RATE, RST_STEP_LENGTH, W_INVERSE_STEP, RST_DECAY_FACTOR,
                  W_TWO_OVER_DAMPING, LEVEL_MIN, 1'b0);
    send_item(OP_INIT, 10'd5, LEVEL_MAX);
    send_item(OP_STEP, 10'd5, LEVEL_MAX);
    send_item(OP_STEP, 10'd5, LEVEL_MIN);
    send_item(OP_STEP, 10'd5, LEVEL_MAX);
    send_item(OP_INIT, 10'd6, '0);
    send_item(OP_STEP, 10'd6, '0);
    drain_results();

    // back-to-back steps on one node, and a node stepped from cleared state
    load_settings(W_DAMPING_RATE, RST_STEP_LENGTH, W_INVERSE_STEP, RST_DECAY_FACTOR,
                  W_TWO_OVER_DAMPING, '0, 1'b0);
    send_item(OP_INIT, 10'd7, $urandom());
    repeat (4) send_item(OP_STEP, 10'd7, ONE);
    send_item(OP_STEP, 10'd7, -ONE);
    send_item(OP_STEP, 10'd512, 3 * ONE);
    send_item(OP_STEP, 10'd512, 3 * ONE);
    send_item(OP_INIT, 10'd512, $urandom());
    send_item(OP_STEP, 10'd7, ONE);
    drain_results();

    // reset settings but a random initial level, no gaps on either side
    load_settings(W_DAMPING_RATE, RST_STEP_LENGTH, W_INVERSE_STEP, RST_DECAY_FACTOR,
                  W_TWO_OVER_DAMPING, $urandom_range(0, 1 << 21) - (1 << 20), 1'b0);
    steady <= 1'b1;
    run_sequences(200);
    drain_results();
    steady <= 1'b0;

    // plausible host settings, long receiver hold lands here
    load_settings($urandom_range(1, 400) << 16, $urandom_range(1, 32'h0100_0000),
                  $urandom_range(65536, 32'h3fff_ffff),
                  $urandom_range(32'hc000_0000, 32'hffff_ffff),
                  $urandom_range(1, 1 << 20), $urandom_range(0, 1 << 21) - (1 << 20), 1'b1);
    run_sequences(200);
    drain_results();

    // everything zero
    load_settings('0, '0, '0, '0, '0, '0, 1'b0);
    run_sequences(150);
    drain_results();

    // everything at the top, upper bit also set in the writes to the narrow registers
    load_settings('1, '1, '1, '1, '1, LEVEL_MAX, 1'b0);
    run_sequences(150);
    drain_results();

    // mixed rails
    load_settings('1, '0, '1, '0, 32'h7fff_ffff, LEVEL_MIN, 1'b1);
    run_sequences(150);
    drain_results();

    // fully random settings
    load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 1'b1);
    run_sequences(250);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d input beats (%0d node loads) and %0d register writes",
             items_sent, inits_sent, reg_writes);
    $display("%0d output beats checked, %0d clipped, %0d mismatches",
             results_seen, clipped_seen, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("** damped_oscillator_node_step: PASSED **");
    else
      $display("** damped_oscillator_node_step: FAILED **");
    $finish;
  end

endmodule
